/* design/key_value_table_with_flush_core_defines.svh */
// Assertion macros shared by the key-value table RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef KEY_VALUE_TABLE_WITH_FLUSH_CORE_DEFINES_SVH
`define KEY_VALUE_TABLE_WITH_FLUSH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KVT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/kvt_pkg.sv */
// Shared types and constants of the key-value table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package kvt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 32;
   localparam int KEY_W               = 32;
   localparam int VALUE_W             = 32;
   localparam int QUEUE_DEPTH         = 2;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_DELETE = 2'd2,
      OP_FLUSH  = 2'd3
   } opcode_type;

   typedef enum logic {
      KIND_REPLY = 1'b0,
      KIND_ENTRY = 1'b1
   } kind_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic signed [KEY_W-1:0]    req_key;
      logic signed [VALUE_W-1:0]  req_value;
   } req_type;

   typedef struct packed {
      logic                       out_kind;
      logic [1:0]                 out_opcode;
      logic signed [KEY_W-1:0]    out_key;
      logic signed [VALUE_W-1:0]  out_value;
      logic                       status;
      logic                       last;
   } rsp_type;

   // decoded request as it sits in the queue between front and back
   typedef struct packed {
      opcode_type                 op;
      logic signed [KEY_W-1:0]    key;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

endpackage

/* design/kvt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on kvt_pkg for default sizes only.
`timescale 1ns / 1ps

module kvt_ram #(
   parameter int WIDTH = kvt_pkg::KEY_W + kvt_pkg::VALUE_W,
   parameter int DEPTH = kvt_pkg::TABLE_DEPTH_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/kvt_front.sv */
// Front end: takes requests, decodes the opcode and queues them for the back end.
// Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kvt_pkg::req_type  req_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output kvt_pkg::cmd_type  cmd_data
);

   localparam int PTR_W = (kvt_pkg::QUEUE_DEPTH > 1) ? $clog2(kvt_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(kvt_pkg::QUEUE_DEPTH + 1);

   kvt_pkg::cmd_type  slot_ff [kvt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   kvt_pkg::cmd_type  cmd_dec;
   logic              push;
   logic              pop;

   // decode
   always_comb begin
      cmd_dec.op    = kvt_pkg::opcode_type'(req_data.opcode);
      cmd_dec.key   = req_data.req_key;
      cmd_dec.value = req_data.req_value;
   end

   assign req_ready = (fill_ff != CNT_W'(kvt_pkg::QUEUE_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd_data  = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(kvt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(kvt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

endmodule

/* design/kvt_back.sv */
// Back end: key match array, valid bits, entry RAM, sequencer and result register.
// Depends on kvt_pkg, kvt_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "key_value_table_with_flush_core_defines.svh"

module kvt_back #(
   parameter int TABLE_DEPTH = kvt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  kvt_pkg::cmd_type  cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kvt_pkg::rsp_type  rsp_data
);

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W   = kvt_pkg::KEY_W;
   localparam int VALUE_W = kvt_pkg::VALUE_W;
   localparam int ENTRY_W = KEY_W + VALUE_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_LOOK  = 5'b00100,
      S_FSCAN = 5'b01000,
      S_FEMIT = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   kvt_pkg::cmd_type          cur_ff, cur_in;
   logic [KEY_W-1:0]          cam_key_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [IDX_W-1:0]          ptr_ff, ptr_in;
   logic                      hit_ff, hit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   kvt_pkg::rsp_type          rsp_ff, rsp_in;

   logic [TABLE_DEPTH-1:0]    match_vec;
   logic                      match_any, free_any;
   logic [IDX_W-1:0]          match_idx, free_idx, ins_idx;
   logic                      out_free;
   logic                      cam_we;
   logic                      ram_we, ram_re;
   logic [IDX_W-1:0]          ram_raddr;
   logic [ENTRY_W-1:0]        ram_wdata, ram_rdata;

   // parallel key compare, then lowest-slot priority pick
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match_vec[i] = valid_ff[i] && (cam_key_ff[i] == cur_ff.key);
      end
   end

   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      free_any  = 1'b0;
      free_idx  = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_any = 1'b1;
            match_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign ins_idx   = match_any ? match_idx : free_idx;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE);
   assign ram_wdata = {cur_ff.key, cur_ff.value};

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cam_we       = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = match_idx;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cur_in   = cmd_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (cur_ff.op)
               kvt_pkg::OP_INSERT: begin
                  if (out_free) begin
                     if (match_any || free_any) begin
                        cam_we            = 1'b1;
                        ram_we            = 1'b1;
                        valid_in[ins_idx] = 1'b1;
                        if (!match_any) begin
                           cnt_in = cnt_ff + CNT_W'(1);
                        end
                     end
                     rsp_valid_in      = 1'b1;
                     rsp_in.out_kind   = kvt_pkg::KIND_REPLY;
                     rsp_in.out_opcode = kvt_pkg::OP_INSERT;
                     rsp_in.out_key    = cur_ff.key;
                     rsp_in.out_value  = cur_ff.value;
                     rsp_in.status     = (match_any || free_any) ? kvt_pkg::STATUS_OK
                                                                 : kvt_pkg::STATUS_FULL;
                     rsp_in.last       = 1'b1;
                     state_in          = S_IDLE;
                  end
               end
               kvt_pkg::OP_LOOKUP: begin
                  ram_re    = 1'b1;
                  ram_raddr = match_idx;
                  hit_in    = match_any;
                  state_in  = S_LOOK;
               end
               kvt_pkg::OP_DELETE: begin
                  if (out_free) begin
                     if (match_any) begin
                        valid_in[match_idx] = 1'b0;
                        cnt_in              = cnt_ff - CNT_W'(1);
                     end
                     rsp_valid_in      = 1'b1;
                     rsp_in.out_kind   = kvt_pkg::KIND_REPLY;
                     rsp_in.out_opcode = kvt_pkg::OP_DELETE;
                     rsp_in.out_key    = cur_ff.key;
                     rsp_in.out_value  = cur_ff.value;
                     rsp_in.status     = kvt_pkg::STATUS_OK;
                     rsp_in.last       = 1'b1;
                     state_in          = S_IDLE;
                  end
               end
               kvt_pkg::OP_FLUSH: begin
                  if (out_free) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.out_kind   = kvt_pkg::KIND_REPLY;
                     rsp_in.out_opcode = kvt_pkg::OP_FLUSH;
                     rsp_in.out_key    = cur_ff.key;
                     rsp_in.out_value  = cur_ff.value;
                     rsp_in.status     = kvt_pkg::STATUS_OK;
                     rsp_in.last       = (cnt_ff == '0);
                     ptr_in            = '0;
                     state_in          = (cnt_ff == '0) ? S_IDLE : S_FSCAN;
                  end
               end
            endcase
         end
         S_LOOK: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.out_kind   = kvt_pkg::KIND_REPLY;
               rsp_in.out_opcode = kvt_pkg::OP_LOOKUP;
               rsp_in.out_key    = cur_ff.key;
               rsp_in.out_value  = hit_ff ? ram_rdata[VALUE_W-1:0] : {VALUE_W{1'b1}};
               rsp_in.status     = kvt_pkg::STATUS_OK;
               rsp_in.last       = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_FSCAN: begin
            // walk slots in order; a valid one is read out and dropped
            if (valid_ff[ptr_ff]) begin
               ram_re           = 1'b1;
               ram_raddr        = ptr_ff;
               valid_in[ptr_ff] = 1'b0;
               state_in         = S_FEMIT;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         S_FEMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.out_kind   = kvt_pkg::KIND_ENTRY;
               rsp_in.out_opcode = kvt_pkg::OP_INSERT;
               rsp_in.out_key    = ram_rdata[ENTRY_W-1:VALUE_W];
               rsp_in.out_value  = ram_rdata[VALUE_W-1:0];
               rsp_in.status     = kvt_pkg::STATUS_OK;
               rsp_in.last       = (cnt_ff == CNT_W'(1));
               cnt_in            = cnt_ff - CNT_W'(1);
               ptr_in            = ptr_ff + IDX_W'(1);
               state_in          = (cnt_ff == CNT_W'(1)) ? S_IDLE : S_FSCAN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      ptr_ff <= ptr_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
      if (cam_we) begin
         cam_key_ff[ins_idx] <= cur_ff.key;
      end
   end

   kvt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ins_idx),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `KVT_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
   `KVT_ASSERT_IMPL(a_cnt_matches_valid, clock, reset, state_ff == S_IDLE, $countones(valid_ff) == cnt_ff, "entry count out of step with valid bits")
   `KVT_ASSERT_IMPL(a_entry_item_form, clock, reset, rsp_valid_ff && rsp_ff.out_kind, (rsp_ff.out_opcode == kvt_pkg::OP_INSERT) && !rsp_ff.status, "flushed entry item malformed")
   `KVT_ASSERT_NEXT(a_flush_empties, clock, reset, (state_ff == S_FEMIT) && (state_in == S_IDLE), valid_ff == '0, "table not empty after flush")
   `KVT_ASSERT_NEXT(a_full_no_change, clock, reset, (state_ff == S_EXEC) && (cur_ff.op == kvt_pkg::OP_INSERT) && out_free && !match_any && !free_any, $stable(valid_ff) && $stable(cnt_ff), "dropped insert changed the table")

endmodule

/* design/key_value_table_with_flush_core.sv */
// Insert, delete and flush replies pass the request queue, the execute state and the
// result register; lookup replies also pass the lookup state. The back takes one item
// at a time and a stalled result register holds it; flush walks slots to the last entry.
// Reset (synchronous, active high) empties the table at once through its valid bits and
// clears the request queue and result register; no clearing pass is needed.
// Top level of the key-value table; depends on kvt_pkg, kvt_front and kvt_back.
`timescale 1ns / 1ps

module key_value_table_with_flush_core #(
   parameter int TABLE_DEPTH = kvt_pkg::TABLE_DEPTH_DEFAULT   // 1 to 63 slots
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kvt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kvt_pkg::rsp_type  rsp_data
);

   // Front/back split: the front decodes each item and parks it in a two-entry queue, so
   // new items keep coming in while the back is busy or its result register is stalled.
   logic              cmd_valid;
   logic              cmd_ready;
   kvt_pkg::cmd_type  cmd_data;

   kvt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   // Back: keys sit in a compare array (lowest matching or free slot wins), keys and
   // values also sit in a RAM that serves lookup reads and the flush walk. Flush echoes
   // the item, then emits each valid entry in slot order with last on the final one.
   kvt_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the key-value table: drives request items, predicts
// every reply and flushed entry, and checks them. Depends on kvt_pkg and
// key_value_table_with_flush_core.
`timescale 1ns / 1ps

module tb_top;
   import kvt_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int TABLE_DEPTH    = TABLE_DEPTH_DEFAULT;
   localparam int POOL_SIZE      = 40;          // more keys than slots, so the table can fill
   localparam int HOLD_CYCLES    = 300;         // long receiver hold-off in the pressure phase
   localparam int TAIL_CYCLES    = 16;          // idle tail after the final drain
   // ~460 items, worst case each a full flush of 33 results under heavy stall;
   // the timeout leaves a wide margin over that.
   localparam int TIMEOUT_CYCLES = 1_500_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the table, updated as each request item is accepted.
   logic [KEY_W-1:0]   slot_key   [TABLE_DEPTH];
   logic [VALUE_W-1:0] slot_value [TABLE_DEPTH];
   bit                 slot_used  [TABLE_DEPTH];

   req_type req_backlog[$];     // items waiting for the driver
   rsp_type awaited_rsps[$];    // predicted results, oldest first
   logic [KEY_W-1:0] key_pool[POOL_SIZE];

   int  items_queued = 0;
   int  items_taken  = 0;
   int  rsp_count    = 0;
   int  entry_count  = 0;
   int  lookup_hits  = 0;
   int  full_drops   = 0;
   int  input_stalls = 0;
   int  fail_count   = 0;

   // Idle controls, set per phase by the stimulus process.
   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   int  hold_left     = 0;
   bit  req_fire      = 1'b0;   // request handshake seen at the last rising edge

   key_value_table_with_flush_core #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Table predictor
   // ------------------------------------------------------------------

   // Appends one predicted result to the tail of the expected list.
   function automatic void add_expected(rsp_type r);
      awaited_rsps.insert(awaited_rsps.size(), r);
   endfunction

   // Lowest valid slot holding the key, or -1.
   function automatic int find_slot(logic [KEY_W-1:0] key);
      int i;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_used[i] && slot_key[i] == key) return i;
      end
      return -1;
   endfunction

   // Applies one accepted request to the shadow table and queues its results.
   function automatic void predict_table_op(req_type r);
      rsp_type reply;
      rsp_type entry;
      int      slot;
      int      count;
      int      n;
      int      i;
      reply            = '0;
      reply.out_kind   = KIND_REPLY;
      reply.out_opcode = r.opcode;
      reply.out_key    = r.req_key;
      reply.out_value  = r.req_value;
      reply.status     = STATUS_OK;
      reply.last       = 1'b1;
      case (r.opcode)
         OP_INSERT: begin
            slot = find_slot(r.req_key);
            if (slot < 0) begin
               for (i = TABLE_DEPTH - 1; i >= 0; i--) begin
                  if (!slot_used[i]) slot = i;
               end
            end
            if (slot < 0) begin
               reply.status = STATUS_FULL;
               full_drops++;
            end else begin
               slot_key[slot]   = r.req_key;
               slot_value[slot] = r.req_value;
               slot_used[slot]  = 1'b1;
            end
            add_expected(reply);
         end
         OP_LOOKUP: begin
            slot = find_slot(r.req_key);
            if (slot < 0) begin
               reply.out_value = '1;
            end else begin
               reply.out_value = slot_value[slot];
               lookup_hits++;
            end
            add_expected(reply);
         end
         OP_DELETE: begin
            slot = find_slot(r.req_key);
            if (slot >= 0) slot_used[slot] = 1'b0;
            add_expected(reply);
         end
         default: begin
            // flush: echo first, then every live entry in slot order
            count = 0;
            for (i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_used[i]) count++;
            end
            reply.last = (count == 0);
            add_expected(reply);
            n = 0;
            for (i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_used[i]) begin
                  n++;
                  entry            = '0;
                  entry.out_kind   = KIND_ENTRY;
                  entry.out_opcode = OP_INSERT;
                  entry.out_key    = slot_key[i];
                  entry.out_value  = slot_value[i];
                  entry.status     = STATUS_OK;
                  entry.last       = (n == count);
                  add_expected(entry);
                  slot_used[i] = 1'b0;
               end
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
      fail_count++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
   endfunction

   function automatic void check_rsp(rsp_type want, rsp_type got);
      if (got.out_kind !== want.out_kind)
         report_field("out_kind", want.out_kind, got.out_kind);
      if (got.out_opcode !== want.out_opcode)
         report_field("out_opcode", want.out_opcode, got.out_opcode);
      if (got.out_key !== want.out_key)
         report_field("out_key", want.out_key, got.out_key);
      if (got.out_value !== want.out_value)
         report_field("out_value", want.out_value, got.out_value);
      if (got.status !== want.status)
         report_field("status", want.status, got.status);
      if (got.last !== want.last)
         report_field("last", want.last, got.last);
   endfunction

   // Monitor: everything is sampled at the rising edge. A request taken at this
   // edge is predicted before any result is popped, so the order is fixed.
   always @(posedge clock) begin
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_valid && req_ready;
         if (req_valid && !req_ready) input_stalls++;
         if (req_fire) begin
            predict_table_op(req_data);
            items_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (rsp_data.out_kind == KIND_ENTRY) entry_count++;
            if (awaited_rsps.size() == 0) begin
               fail_count++;
               $display("%0t ns: result mismatch, expected none, got %h",
                        $time, rsp_data);
            end else begin
               check_rsp(awaited_rsps.pop_front(), rsp_data);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Driver and receiver, both on the falling edge
   // ------------------------------------------------------------------

   // Request driver: valid stays up with the same item until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, or a counted hold-off when one is armed.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   task automatic queue_req(opcode_type op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      req_type r;
      r.opcode    = op;
      r.req_key   = key;
      r.req_value = value;
      req_backlog.insert(req_backlog.size(), r);
      items_queued++;
   endtask

   // Random word, leaning on the sign and range extremes now and then.
   function automatic logic [31:0] rand_word();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Mixed traffic over the key pool, so lookups and deletes mostly hit.
   task automatic run_mixed(int n);
      int               i;
      int               pick;
      logic [KEY_W-1:0] key;
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         key  = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(POOL_SIZE - 1)];
         if (pick < 40)      queue_req(OP_INSERT, key, rand_word());
         else if (pick < 70) queue_req(OP_LOOKUP, key, rand_word());
         else if (pick < 95) queue_req(OP_DELETE, key, rand_word());
         else                queue_req(OP_FLUSH, rand_word(), rand_word());
      end
   endtask

   // Fill the table past capacity, probe it, free one slot and refill, then flush.
   // 43 items.
   task automatic run_fill();
      logic [KEY_W-1:0] fresh[TABLE_DEPTH + 2];
      int               i;
      for (i = 0; i < TABLE_DEPTH + 2; i++) begin
         fresh[i] = $urandom;
         queue_req(OP_INSERT, fresh[i], rand_word());
      end
      queue_req(OP_INSERT, fresh[3], rand_word());          // overwrite while full
      for (i = 0; i < 4; i++)
         queue_req(OP_LOOKUP, fresh[$urandom_range(TABLE_DEPTH + 1)], rand_word());
      queue_req(OP_DELETE, fresh[$urandom_range(TABLE_DEPTH - 1)], rand_word());
      queue_req(OP_INSERT, $urandom, rand_word());          // lands in the freed slot
      queue_req(OP_INSERT, $urandom, rand_word());          // full again, dropped
      queue_req(OP_FLUSH, rand_word(), rand_word());
   endtask

   task automatic run_random(int budget);
      int base;
      base = items_queued;
      while (items_queued - base < budget) begin
         if ($urandom_range(3) == 0) run_fill();
         else                        run_mixed(20);
      end
   endtask

   // Sender pause: nothing new until every queued item is taken and answered.
   task automatic wait_drained();
      while (items_taken != items_queued || awaited_rsps.size() != 0) @(posedge clock);
   endtask

   initial begin
      int i;
      for (i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-table cases, field extremes, overwrite, slot reuse, flush order.
      queue_req(OP_FLUSH,  32'h1234_5678, 32'h9ABC_DEF0);   // flush of an empty table
      queue_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);   // miss -> all ones
      queue_req(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // absent key
      queue_req(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_req(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_req(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_req(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_req(OP_INSERT, 32'h0000_0000, 32'h0000_0005);   // overwrite in place
      queue_req(OP_LOOKUP, 32'h8000_0000, 32'hA5A5_A5A5);
      queue_req(OP_LOOKUP, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
      queue_req(OP_LOOKUP, 32'h0000_0000, 32'h5A5A_5A5A);
      queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
      queue_req(OP_DELETE, 32'h7FFF_FFFF, 32'h0000_0001);
      queue_req(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);   // miss after delete
      queue_req(OP_INSERT, 32'h5A5A_5A5A, 32'h3C3C_3C3C);   // reuses freed slot 1
      queue_req(OP_DELETE, 32'h8000_0000, 32'hFFFF_FFFF);   // hole at slot 0
      queue_req(OP_FLUSH,  32'h0000_0000, 32'h0000_0000);   // entries in slot order
      queue_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);   // table empty again
      queue_req(OP_FLUSH,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_drained();

      // No idling at all.
      run_random(100);
      wait_drained();

      // Sender mostly idle.
      send_idle_pct = 87;
      run_random(90);
      wait_drained();

      // Receiver mostly stalling.
      send_idle_pct = 0;
      stall_pct     = 87;
      run_random(90);
      wait_drained();

      // Light idling on both sides.
      send_idle_pct = 9;
      stall_pct     = 9;
      run_random(90);
      wait_drained();

      // Backpressure: receiver holds off while the sender keeps offering items,
      // so the request queue fills and the input stalls; the flush then drains.
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = HOLD_CYCLES;
      run_fill();
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_rsps.size() != 0) begin
         fail_count += awaited_rsps.size();
         $display("%0t ns: %0d expected results never arrived", $time, awaited_rsps.size());
      end

      $display("Covered %0d request items and %0d results: %0d lookup hits, %0d inserts dropped",
               items_taken, rsp_count, lookup_hits, full_drops);
      $display("on a full table, %0d flushed entries, %0d cycles of input backpressure.",
               entry_count, input_stalls);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
      $display("== FAIL ==");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/kvt_pkg.sv
design/kvt_ram.sv
design/kvt_front.sv
design/kvt_back.sv
design/key_value_table_with_flush_core.sv
sim/tb_top.sv
